// File: rtl/phagc_pkg.sv
`default_nettype none

package phagc_pkg;

  // Field widths
  localparam int unsigned PeakW  = 16;
  localparam int unsigned GainW  = 32;
  localparam int unsigned HangW  = 16;
  localparam int unsigned RampW  = 17;
  localparam int unsigned RampFracW = 16;
  localparam int unsigned ProdW  = GainW + RampW;

  // Stream and register port widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // Depth of the peak ring
  localparam int unsigned AttackTicksDefault = 2;

  // Restoring divider: one quotient bit per step
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register reset values
  localparam logic [PeakW-1:0] NominalReset = 16'd16384;
  localparam logic [HangW-1:0] HangReset    = 16'd30;
  localparam logic [RampW-1:0] RampReset    = 17'd68813;
  localparam logic [GainW-1:0] MaxGainReset = 32'd33554432;
  localparam logic [GainW-1:0] GainUnity    = 32'd16777216;

  typedef enum logic [1:0] {
    RegNominal = 2'd0,
    RegHang    = 2'd1,
    RegRamp    = 2'd2,
    RegMaxGain = 2'd3
  } reg_idx_e;

endpackage

`default_nettype wire

// File: rtl/peak_hang_agc_top.sv
`default_nettype none

// Peak-hang AGC. Each input word is one tick carrying the peak output magnitude
// (Q1.15). The block keeps the last ATTACK_TICKS peaks, a hang counter and a
// Q8.24 gain. When every stored peak is above the nominal level, or some are
// and the hang time has run out, the gain is scaled by nominal / largest peak
// (floored, never below 1 LSB) and the hang counter clears; otherwise a peak
// below nominal advances the hang counter. Once the hang time is reached the
// gain is multiplied by ramp_factor (Q1.16), and finally clamped to max_gain.
// Each result word gives the new gain plus the attack and ramp flags.
// The peak scan visits one ring entry per cycle, one shared 32x17 multiplier
// serves the attack product and the ramp, and the attack division runs one
// quotient bit per cycle. A result that the sink does not take holds the
// sequencer in its last step. The input side is ready only while the
// sequencer is idle; a finished result sits in the output register and the
// next word is taken while it waits. Registers are to be written over the
// APB port only while the block is idle; the block itself does not enforce
// this. Map: 0x0 nominal_level, 0x4 hang_ticks, 0x8 ramp_factor, 0xC max_gain.
module peak_hang_agc_top #(
  parameter int unsigned ATTACK_TICKS = phagc_pkg::AttackTicksDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream: [15:0] peak_level
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [phagc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // output stream: tdata [31:0] applied_gain
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [phagc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // tuser [0] gain_reduced, [1] ramping
  output logic [phagc_pkg::OutUserW-1:0]      m_axis_tuser_o,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [phagc_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [phagc_pkg::ApbDataW-1:0] pwdata,
  output logic [phagc_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned SlotW = (ATTACK_TICKS > 1) ? $clog2(ATTACK_TICKS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(ATTACK_TICKS - 1);

  localparam int unsigned PeakW = phagc_pkg::PeakW;
  localparam int unsigned GainW = phagc_pkg::GainW;
  localparam int unsigned HangW = phagc_pkg::HangW;
  localparam int unsigned RampW = phagc_pkg::RampW;
  localparam int unsigned ProdW = phagc_pkg::ProdW;
  localparam int unsigned FracW = phagc_pkg::RampFracW;
  localparam int unsigned CntW  = phagc_pkg::DivCntW;
  localparam logic [CntW-1:0] DivLast = CntW'(phagc_pkg::DivSteps - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL_ATT,
    ST_DIV,
    ST_ATT_FIX,
    ST_RAMP_CHK,
    ST_MUL_RAMP,
    ST_RAMP_FIX,
    ST_CLAMP
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PeakW-1:0] nominal_q;
  logic [HangW-1:0] hang_ticks_q;
  logic [RampW-1:0] ramp_factor_q;
  logic [GainW-1:0] max_gain_q;
  logic             cfg_we;
  phagc_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = phagc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q     <= phagc_pkg::NominalReset;
      hang_ticks_q  <= phagc_pkg::HangReset;
      ramp_factor_q <= phagc_pkg::RampReset;
      max_gain_q    <= phagc_pkg::MaxGainReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        phagc_pkg::RegNominal: nominal_q     <= pwdata[PeakW-1:0];
        phagc_pkg::RegHang:    hang_ticks_q  <= pwdata[HangW-1:0];
        phagc_pkg::RegRamp:    ramp_factor_q <= pwdata[RampW-1:0];
        phagc_pkg::RegMaxGain: max_gain_q    <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      phagc_pkg::RegNominal: prdata = {16'd0, nominal_q};
      phagc_pkg::RegHang:    prdata = {16'd0, hang_ticks_q};
      phagc_pkg::RegRamp:    prdata = {15'd0, ramp_factor_q};
      phagc_pkg::RegMaxGain: prdata = max_gain_q;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  state_e           state_q;
  logic [PeakW-1:0] peaks_q [ATTACK_TICKS];
  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] scan_q;
  logic [HangW-1:0] hang_q;
  logic [GainW-1:0] gain_q;
  logic [PeakW-1:0] peak_q;
  logic [PeakW-1:0] largest_q;
  logic             all_above_q;
  logic             any_above_q;
  logic             reduced_q;
  logic             ramped_q;
  logic [PeakW-1:0] rem_q;
  logic [GainW-1:0] quo_q;
  logic [CntW-1:0]  div_cnt_q;
  logic [ProdW-FracW-1:0] ramp_prod_q;
  logic             out_valid_q;
  logic [GainW-1:0] out_gain_q;
  logic             out_reduced_q;
  logic             out_ramped_q;

  logic             in_accept;
  logic             hang_expired;
  logic [PeakW-1:0] scan_peak;
  logic             scan_above;
  logic [RampW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;
  logic [PeakW:0]   div_trial;
  logic             div_ge;
  logic [PeakW:0]   div_diff;
  logic [GainW-1:0] gain_clamped;

  assign in_accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign hang_expired = (hang_q >= hang_ticks_q);
  assign scan_peak    = peaks_q[scan_q];
  assign scan_above   = (scan_peak > nominal_q);

  // Shared multiplier: nominal for the attack product, ramp factor otherwise
  assign mul_b = (state_q == ST_MUL_ATT) ? {1'b0, nominal_q} : ramp_factor_q;
  assign mul_p = ProdW'(gain_q) * ProdW'(mul_b);

  // One restoring division step; remainder always stays below the divisor
  assign div_trial = {rem_q, quo_q[GainW-1]};
  assign div_ge    = (div_trial >= {1'b0, largest_q});
  assign div_diff  = div_trial - {1'b0, largest_q};

  always_comb begin
    gain_clamped = (gain_q > max_gain_q) ? max_gain_q : gain_q;
    if (gain_clamped == '0) begin
      gain_clamped = GainW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < ATTACK_TICKS; i++) begin
        peaks_q[i] <= '0;
      end
      slot_q        <= '0;
      scan_q        <= '0;
      hang_q        <= '0;
      gain_q        <= phagc_pkg::GainUnity;
      peak_q        <= '0;
      largest_q     <= '0;
      all_above_q   <= 1'b0;
      any_above_q   <= 1'b0;
      reduced_q     <= 1'b0;
      ramped_q      <= 1'b0;
      rem_q         <= '0;
      quo_q         <= '0;
      div_cnt_q     <= '0;
      ramp_prod_q   <= '0;
      out_valid_q   <= 1'b0;
      out_gain_q    <= '0;
      out_reduced_q <= 1'b0;
      out_ramped_q  <= 1'b0;
    end else begin
      // drop the result once the sink takes it; the last step refills it itself
      if (out_valid_q && m_axis_tready_i && (state_q != ST_CLAMP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            // store the peak and advance the ring slot
            peaks_q[slot_q] <= s_axis_tdata_i[PeakW-1:0];
            slot_q          <= (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
            peak_q          <= s_axis_tdata_i[PeakW-1:0];
            scan_q          <= '0;
            all_above_q     <= 1'b1;
            any_above_q     <= 1'b0;
            largest_q       <= '0;
            reduced_q       <= 1'b0;
            ramped_q        <= 1'b0;
            state_q         <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // one ring entry per cycle: above-nominal flags and running maximum
          all_above_q <= all_above_q && scan_above;
          any_above_q <= any_above_q || scan_above;
          if (scan_peak > largest_q) begin
            largest_q <= scan_peak;
          end
          if (scan_q == LastSlot) begin
            state_q <= ST_DECIDE;
          end else begin
            scan_q <= scan_q + SlotW'(1);
          end
        end

        ST_DECIDE: begin
          if (all_above_q || (any_above_q && hang_expired)) begin
            hang_q    <= '0;
            reduced_q <= 1'b1;
            state_q   <= ST_MUL_ATT;
          end else begin
            if ((peak_q < nominal_q) && (hang_q != '1)) begin
              hang_q <= hang_q + HangW'(1);
            end
            state_q <= ST_RAMP_CHK;
          end
        end

        ST_MUL_ATT: begin
          // gain * nominal < 2^32 * largest, so the quotient fits in 32 bits
          rem_q     <= mul_p[GainW+PeakW-1:GainW];
          quo_q     <= mul_p[GainW-1:0];
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end

        ST_DIV: begin
          rem_q     <= div_ge ? div_diff[PeakW-1:0] : div_trial[PeakW-1:0];
          quo_q     <= {quo_q[GainW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + CntW'(1);
          if (div_cnt_q == DivLast) begin
            state_q <= ST_ATT_FIX;
          end
        end

        ST_ATT_FIX: begin
          gain_q  <= (quo_q == '0) ? GainW'(1) : quo_q;
          state_q <= ST_RAMP_CHK;
        end

        ST_RAMP_CHK: begin
          if (hang_expired) begin
            ramped_q <= 1'b1;
            state_q  <= ST_MUL_RAMP;
          end else begin
            state_q <= ST_CLAMP;
          end
        end

        ST_MUL_RAMP: begin
          ramp_prod_q <= mul_p[ProdW-1:FracW];
          state_q     <= ST_RAMP_FIX;
        end

        ST_RAMP_FIX: begin
          // saturate to 32 bits, floor at 1 LSB
          if (ramp_prod_q[GainW]) begin
            gain_q <= '1;
          end else if (ramp_prod_q[GainW-1:0] == '0) begin
            gain_q <= GainW'(1);
          end else begin
            gain_q <= ramp_prod_q[GainW-1:0];
          end
          state_q <= ST_CLAMP;
        end

        ST_CLAMP: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            gain_q        <= gain_clamped;
            out_gain_q    <= gain_clamped;
            out_reduced_q <= reduced_q;
            out_ramped_q  <= ramped_q;
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_gain_q;
  assign m_axis_tuser_o  = {out_ramped_q, out_reduced_q};

`ifndef NO_ASSERTIONS
  // the division remainder never reaches the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < largest_q)
    else $error("divider remainder out of range");

  // an attack needs a nonzero largest peak above nominal
  a_att_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_ATT |-> largest_q > nominal_q)
    else $error("attack without a peak above nominal");

  // a delivered gain is never zero and never above the ceiling, unless the ceiling is zero
  a_gain_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o != '0) &&
                        ((m_axis_tdata_o <= max_gain_q) || (max_gain_q == '0)))
    else $error("applied gain out of range");

  // an accepted word starts the scan and blocks further input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o && state_q == ST_SCAN)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire
